// ===== design/radix_p_digit_serial_arithmetic_defines.svh =====
// Assertion macros shared by the radix-p digit-serial arithmetic block
`ifndef RADIX_P_DIGIT_SERIAL_ARITHMETIC_DEFINES_SVH
`define RADIX_P_DIGIT_SERIAL_ARITHMETIC_DEFINES_SVH
`ifndef NO_ASSERTIONS
// antecedent holds -> consequent holds in the same cycle
`define RPD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpd assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define RPD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpd assertion failed");
`else
`define RPD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RPD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/rpd_pkg.sv =====
// Types and constants for the radix-p digit-serial arithmetic block
`timescale 1ns / 1ps
package rpd_pkg;
  localparam int MAX_BASE = 16;
  localparam int BASE_TOP_RAW = (MAX_BASE > 16) ? 16 : MAX_BASE;
  localparam int BASE_TOP = (BASE_TOP_RAW < 2) ? 2 : BASE_TOP_RAW;

  localparam int T_W = 8;         // widest intermediate: 15*16 + 15
  localparam int DV_W = 5;        // divisor: base up to 16 or a digit
  localparam int DIV_ITER = T_W / 2;  // two quotient bits a cycle
  localparam int CNT_W = $clog2(DIV_ITER);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] KIND_DIGIT = 2'd0;
  localparam logic [1:0] KIND_CARRY = 2'd1;
  localparam logic [1:0] KIND_REM   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DIG  = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_BORROW   = 2'd3;

  localparam logic [4:0] BASE_RESET = 5'd10;

  typedef struct packed {
    logic             start;
    logic [T_W-1:0]   dividend;
    logic [DV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [T_W-1:0]   quot;
    logic [3:0]       rem;
  } div_res_t;

  typedef struct packed {
    logic [3:0] digit;
    logic [1:0] kind;
    logic [1:0] status;
    logic       last;
  } res_t;
endpackage

// ===== design/rpd_if.sv =====
// Valid/ready channel interfaces for input digits and result items
`timescale 1ns / 1ps
interface rpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [3:0] digit_a;
  logic [3:0] digit_b;
  logic       last_in;
  modport source (output valid, op, digit_a, digit_b, last_in, input ready);
  modport sink (input valid, op, digit_a, digit_b, last_in, output ready);
endinterface

interface rpd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_out;
  logic [1:0] kind;
  logic [1:0] status;
  logic       last_out;
  modport source (output valid, digit_out, kind, status, last_out, input ready);
  modport sink (input valid, digit_out, kind, status, last_out, output ready);
endinterface

// ===== design/rpd_div.sv =====
// Shared restoring divider, two quotient bits per cycle
`timescale 1ns / 1ps
module rpd_div (
  input  logic              clk,
  input  logic              rst,
  input  rpd_pkg::div_req_t req,
  output rpd_pkg::div_res_t res
);
  logic                       busy;
  logic                       done;
  logic [rpd_pkg::CNT_W-1:0]  cnt;
  logic [rpd_pkg::T_W-1:0]    q;
  logic [rpd_pkg::DV_W-1:0]   r;
  logic [rpd_pkg::DV_W-1:0]   dv;

  logic [rpd_pkg::DV_W-1:0]   r1, r1s, r2, r2s;
  logic                       ge1, ge2;
  logic [rpd_pkg::T_W-1:0]    q_next;

  // remainder stays below the divisor (at most 16), so its low four bits
  // carry everything into the next shift
  always_comb begin
    r1 = {r[3:0], q[rpd_pkg::T_W-1]};
    ge1 = (r1 >= dv);
    r1s = ge1 ? (r1 - dv) : r1;
    r2 = {r1s[3:0], q[rpd_pkg::T_W-2]};
    ge2 = (r2 >= dv);
    r2s = ge2 ? (r2 - dv) : r2;
    q_next = {q[rpd_pkg::T_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        q <= req.dividend;
        r <= '0;
        dv <= req.divisor;
      end else if (busy) begin
        q <= q_next;
        r <= r2s;
        cnt <= cnt + 1'b1;
        if (cnt == rpd_pkg::CNT_W'(rpd_pkg::DIV_ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.busy = busy;
  assign res.done = done;
  assign res.quot = q;
  assign res.rem = r[3:0];
endmodule

// ===== design/radix_p_digit_serial_arithmetic.sv =====
// Top level: digit sequencer around the shared divider
// Each input beat starts the divider; after its 4 divider steps the results are latched,
// and then they are loaded one by one into the output register.
// A held-off output stalls the sequencer in its emit step. Input is taken only when idle,
// so a new input beat is accepted only once every result of the last one has been loaded.
// Synchronous active-high reset: base 10, running carry 0, channels empty.
`timescale 1ns / 1ps
`include "radix_p_digit_serial_arithmetic_defines.svh"
module radix_p_digit_serial_arithmetic (
  input  logic      clk,
  input  logic      rst,
  input  logic      base_we,
  input  logic [4:0] base_wdata,
  rpd_in_if.sink    din,
  rpd_out_if.source dout
);
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT0, S_EMIT1} state_t;

  state_t state;
  logic [4:0] base;
  logic [3:0] carry;

  logic [1:0] op_r;
  logic       last_r;
  logic       bad_r;
  logic       dz_r;
  logic [3:0] sd_r;
  logic       sb_r;
  logic [4:0] dvs_r;
  rpd_pkg::res_t res0_r, res1_r;
  logic       two_r;

  logic          out_valid;
  rpd_pkg::res_t out_r;

  rpd_pkg::div_req_t div_req;
  rpd_pkg::div_res_t div_res;

  logic [4:0] p_eff;
  logic       accept;
  logic       out_free;
  logic       out_load;
  logic [3:0] mx, addend;
  logic [4:0] my;
  logic [8:0] prod;
  logic [7:0] t_mul, t_add;
  logic [4:0] sub, dvs;
  logic [4:0] diff;
  logic       borrow;
  logic       bad, dz;

  rpd_pkg::res_t res0_next, res1_next;
  logic          two_next;
  logic [3:0]    carry_next;

  always_comb begin
    if (base < 5'd2) p_eff = 5'd2;
    else if (base > 5'(rpd_pkg::BASE_TOP)) p_eff = 5'(rpd_pkg::BASE_TOP);
    else p_eff = base;
  end

  assign accept = din.valid && din.ready;
  assign din.ready = (state == S_IDLE);
  assign out_free = !out_valid || dout.ready;
  assign out_load = out_free && ((state == S_EMIT0) || (state == S_EMIT1));

  // one multiplier serves a*b and carry*p
  always_comb begin
    mx = (din.op == rpd_pkg::OP_DIV) ? carry : din.digit_a;
    my = (din.op == rpd_pkg::OP_DIV) ? p_eff : {1'b0, din.digit_b};
    addend = (din.op == rpd_pkg::OP_DIV) ? din.digit_a : carry;
    prod = {5'b0, mx} * {4'b0, my};
    t_mul = prod[7:0] + {4'b0, addend};
    t_add = {4'b0, din.digit_a} + {4'b0, din.digit_b} + {4'b0, carry};
    dvs = (din.op == rpd_pkg::OP_DIV) ? {1'b0, din.digit_b} : p_eff;
    sub = {1'b0, din.digit_b} + {4'b0, (carry != 4'd0)};
    borrow = ({1'b0, din.digit_a} < sub);
    diff = borrow ? ({1'b0, din.digit_a} + p_eff - sub) : ({1'b0, din.digit_a} - sub);
    bad = ({1'b0, din.digit_a} >= p_eff) || ({1'b0, din.digit_b} >= p_eff);
    dz = (din.op == rpd_pkg::OP_DIV) && (din.digit_b == 4'd0);
  end

  always_comb begin
    div_req.start = accept;
    div_req.dividend = (din.op == rpd_pkg::OP_ADD) ? t_add : t_mul;
    div_req.divisor = dvs;
  end

  rpd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  // result items and carry update once the quotient is ready
  always_comb begin
    res1_next = '{digit: div_res.quot[3:0], kind: rpd_pkg::KIND_CARRY,
                  status: rpd_pkg::ST_OK, last: 1'b1};
    two_next = 1'b0;
    carry_next = 4'd0;
    res0_next = '{digit: div_res.quot[3:0], kind: rpd_pkg::KIND_DIGIT,
                  status: rpd_pkg::ST_OK, last: last_r};
    if (bad_r || dz_r) begin
      res0_next.digit = 4'd0;
      res0_next.status = bad_r ? rpd_pkg::ST_BAD_DIG : rpd_pkg::ST_DIV_ZERO;
      carry_next = last_r ? 4'd0 : carry;
    end else begin
      case (op_r)
        rpd_pkg::OP_DIV: begin
          res0_next.last = 1'b0;
          res1_next = '{digit: div_res.rem, kind: rpd_pkg::KIND_REM,
                        status: rpd_pkg::ST_OK, last: 1'b1};
          two_next = last_r;
          carry_next = last_r ? 4'd0 : div_res.rem;
        end
        rpd_pkg::OP_SUB: begin
          res0_next.digit = sd_r;
          res0_next.status = (last_r && sb_r) ? rpd_pkg::ST_BORROW : rpd_pkg::ST_OK;
          carry_next = last_r ? 4'd0 : {3'b0, sb_r};
        end
        default: begin
          // quotient by p is the carry; remainder is the digit
          res0_next.digit = div_res.rem;
          res1_next.digit = div_res.quot[3:0];
          two_next = last_r && (div_res.quot[3:0] != 4'd0);
          res0_next.last = last_r && !two_next;
          carry_next = last_r ? 4'd0 : div_res.quot[3:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      base <= rpd_pkg::BASE_RESET;
      carry <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (base_we) base <= base_wdata;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && dout.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r <= din.op;
            last_r <= din.last_in;
            bad_r <= bad;
            dz_r <= dz;
            sd_r <= diff[3:0];
            sb_r <= borrow;
            dvs_r <= dvs;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            res0_r <= res0_next;
            res1_r <= res1_next;
            two_r <= two_next;
            carry <= carry_next;
            state <= S_EMIT0;
          end
        end
        S_EMIT0: begin
          if (out_free) begin
            out_r <= res0_r;
            state <= two_r ? S_EMIT1 : S_IDLE;
          end
        end
        S_EMIT1: begin
          if (out_free) begin
            out_r <= res1_r;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign dout.valid = out_valid;
  assign dout.digit_out = out_r.digit;
  assign dout.kind = out_r.kind;
  assign dout.status = out_r.status;
  assign dout.last_out = out_r.last;

  `RPD_ASSERT_IMP(a_start_idle, clk, rst, div_req.start, !div_res.busy)
  `RPD_ASSERT_NXT(a_done_emit, clk, rst, state == S_DIV && div_res.done, state == S_EMIT0)
  `RPD_ASSERT_IMP(a_rem_below, clk, rst, div_res.done && dvs_r != 5'd0,
                  {1'b0, div_res.rem} < dvs_r)
  `RPD_ASSERT_IMP(a_carry_clr, clk, rst, state == S_EMIT0 && last_r, carry == 4'd0)
  `RPD_ASSERT_IMP(a_two_only, clk, rst, state == S_EMIT1, two_r && last_r)
endmodule

// ===== sim/rpd_digit_monitor.sv =====
// Watches both channels, predicts the radix-p result beats and compares them
`timescale 1ns / 1ps
module rpd_digit_monitor (
  input  logic       clk,
  input  logic       rst,
  input  logic       base_we,
  input  logic [4:0] base_wdata,
  rpd_in_if          din,
  rpd_out_if         dout,
  output int         errors,
  output int         outstanding,
  output int         results_seen
);
  logic [4:0]    radix_reg = rpd_pkg::BASE_RESET;
  logic [3:0]    carry_reg = '0;
  rpd_pkg::res_t want_q[$];
  int            mism = 0;
  int            pending = 0;
  int            seen = 0;

  assign errors       = mism;
  assign outstanding  = pending;
  assign results_seen = seen;

  function automatic int eff_radix(input logic [4:0] v);
    if (v < 2) return 2;
    if (v > rpd_pkg::BASE_TOP) return rpd_pkg::BASE_TOP;
    return int'(v);
  endfunction

  function automatic rpd_pkg::res_t mk(input int d, input logic [1:0] k,
                                       input logic [1:0] s, input logic l);
    rpd_pkg::res_t r;
    r.digit  = d[3:0];
    r.kind   = k;
    r.status = s;
    r.last   = l;
    return r;
  endfunction

  // one digit through the sequencer; returns the number of result beats queued
  function automatic int radix_step(input logic [1:0] op, input logic [3:0] a,
                                    input logic [3:0] b, input logic last);
    int p, c, t, d, sub;
    bit borrow;
    p = eff_radix(radix_reg);
    c = int'(carry_reg);
    if (a >= p || b >= p) begin
      want_q.push_back(mk(0, rpd_pkg::KIND_DIGIT, rpd_pkg::ST_BAD_DIG, last));
      if (last) carry_reg = '0;
      return 1;
    end
    case (op)
      rpd_pkg::OP_DIV: begin
        if (b == 0) begin
          want_q.push_back(mk(0, rpd_pkg::KIND_DIGIT, rpd_pkg::ST_DIV_ZERO, last));
          if (last) carry_reg = '0;
          return 1;
        end
        t = c * p + int'(a);
        d = t / int'(b);
        c = t % int'(b);
        want_q.push_back(mk(d, rpd_pkg::KIND_DIGIT, rpd_pkg::ST_OK, 1'b0));
        if (last) begin
          want_q.push_back(mk(c, rpd_pkg::KIND_REM, rpd_pkg::ST_OK, 1'b1));
          carry_reg = '0;
          return 2;
        end
        carry_reg = c[3:0];
        return 1;
      end
      rpd_pkg::OP_SUB: begin
        sub    = int'(b) + ((c != 0) ? 1 : 0);
        borrow = int'(a) < sub;
        d      = borrow ? int'(a) + p - sub : int'(a) - sub;
        want_q.push_back(mk(d, rpd_pkg::KIND_DIGIT,
                            (last && borrow) ? rpd_pkg::ST_BORROW : rpd_pkg::ST_OK, last));
        carry_reg = last ? 4'd0 : {3'd0, borrow};
        return 1;
      end
      default: begin
        t = (op == rpd_pkg::OP_ADD) ? int'(a) + int'(b) + c : int'(a) * int'(b) + c;
        d = t % p;
        c = t / p;
        if (last && c != 0) begin
          want_q.push_back(mk(d, rpd_pkg::KIND_DIGIT, rpd_pkg::ST_OK, 1'b0));
          want_q.push_back(mk(c, rpd_pkg::KIND_CARRY, rpd_pkg::ST_OK, 1'b1));
          carry_reg = '0;
          return 2;
        end
        want_q.push_back(mk(d, rpd_pkg::KIND_DIGIT, rpd_pkg::ST_OK, last));
        carry_reg = last ? 4'd0 : c[3:0];
        return 1;
      end
    endcase
  endfunction

  task automatic report(input string what);
    mism++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    rpd_pkg::res_t got;
    rpd_pkg::res_t exp;
    if (rst) begin
      radix_reg = rpd_pkg::BASE_RESET;
      carry_reg = '0;
      want_q.delete();
      pending <= 0;
    end else begin
      if (base_we) radix_reg = base_wdata;
      if (din.valid && din.ready)
        void'(radix_step(din.op, din.digit_a, din.digit_b, din.last_in));
      if (dout.valid && dout.ready) begin
        got = {dout.digit_out, dout.kind, dout.status, dout.last_out};
        seen++;
        if (want_q.size() == 0) begin
          report($sformatf("result beat digit %0d kind %0d status %0d last %0d unexpected",
                           got.digit, got.kind, got.status, got.last));
        end else begin
          exp = want_q.pop_front();
          if (got != exp)
            report($sformatf("got digit %0d kind %0d status %0d last %0d, want %0d %0d %0d %0d",
                             got.digit, got.kind, got.status, got.last,
                             exp.digit, exp.kind, exp.status, exp.last));
        end
      end
      pending <= want_q.size();
    end
  end
endmodule

// ===== sim/radix_p_digit_serial_arithmetic_tb.sv =====
// Testbench top: digit stimulus, channel idling, radix settings and verdict
`timescale 1ns / 1ps
module radix_p_digit_serial_arithmetic_tb;
  localparam int CYCLE_LIMIT = 250000;
  localparam int PHASE_ITEMS = 50;

  logic       clk;
  logic       rst;
  logic       base_we;
  logic [4:0] base_wdata;
  int         errors;
  int         outstanding;
  int         results_seen;
  int         cycles = 0;
  int         sent = 0;
  int         radix = 10;
  bit         no_gaps = 0;
  logic [4:0] base_plan [12] = '{5'd16, 5'd2, 5'd0, 5'd1, 5'd31, 5'd17,
                                 5'd3, 5'd7, 5'd10, 5'd13, 5'd16, 5'd5};

  rpd_in_if  din ();
  rpd_out_if dout ();

  radix_p_digit_serial_arithmetic u_top (
    .clk        (clk),
    .rst        (rst),
    .base_we    (base_we),
    .base_wdata (base_wdata),
    .din        (din),
    .dout       (dout)
  );

  rpd_digit_monitor u_mon (
    .clk          (clk),
    .rst          (rst),
    .base_we      (base_we),
    .base_wdata   (base_wdata),
    .din          (din),
    .dout         (dout),
    .errors       (errors),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("radix_p_digit_serial_arithmetic_tb failed");
      $finish;
    end
  end

  always @(posedge clk) dout.ready <= !rst && (no_gaps || ($urandom_range(0, 99) >= 21));

  task automatic send_digit(input logic [1:0] op, input logic [3:0] a, input logic [3:0] b,
                            input logic last);
    while (!no_gaps && $urandom_range(0, 99) < 21) begin
      din.valid <= 1'b0;
      @(posedge clk);
    end
    din.valid   <= 1'b1;
    din.op      <= op;
    din.digit_a <= a;
    din.digit_b <= b;
    din.last_in <= last;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    sent++;
  endtask

  // hold the input off until every result beat is back, then let the divider settle
  task automatic drain();
    din.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_base(input logic [4:0] v);
    base_we    <= 1'b1;
    base_wdata <= v;
    @(posedge clk);
    base_we <= 1'b0;
    radix = (v < 2) ? 2 : ((v > rpd_pkg::BASE_TOP) ? rpd_pkg::BASE_TOP : int'(v));
  endtask

  // one number, digits valid in the current radix unless spoilt
  task automatic send_run(input logic [1:0] op, input int len, input bit spoilt,
                          input bit open_end);
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] fixed_b;
    int         bad_at;
    fixed_b = 4'($urandom_range(0, radix - 1));
    if (op == rpd_pkg::OP_DIV && $urandom_range(0, 9) != 0)
      fixed_b = 4'($urandom_range(1, radix - 1));
    bad_at = (spoilt && radix < 16) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      a = 4'($urandom_range(0, radix - 1));
      b = (op == rpd_pkg::OP_MUL || op == rpd_pkg::OP_DIV) ? fixed_b :
          4'($urandom_range(0, radix - 1));
      if (i == bad_at) begin
        if ($urandom_range(0, 1) != 0) a = 4'($urandom_range(radix, 15));
        else b = 4'($urandom_range(radix, 15));
      end
      send_digit(op, a, b, (i == len - 1) && !open_end);
    end
  endtask

  initial begin
    int  in_phase;
    int  len;
    bit  mid_done;
    logic [1:0] op;
    rst        <= 1'b1;
    base_we    <= 1'b0;
    base_wdata <= '0;
    din.valid  <= 1'b0;
    din.op     <= rpd_pkg::OP_ADD;
    din.digit_a <= '0;
    din.digit_b <= '0;
    din.last_in <= 1'b0;
    mid_done = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, in the reset radix of ten
    send_digit(rpd_pkg::OP_ADD, 4'd0, 4'd0, 1'b1);
    send_digit(rpd_pkg::OP_ADD, 4'd9, 4'd9, 1'b0);      // final carry out
    send_digit(rpd_pkg::OP_ADD, 4'd9, 4'd9, 1'b1);
    send_digit(rpd_pkg::OP_SUB, 4'd5, 4'd3, 1'b1);
    send_digit(rpd_pkg::OP_SUB, 4'd3, 4'd5, 1'b0);      // borrow right through
    send_digit(rpd_pkg::OP_SUB, 4'd0, 4'd0, 1'b1);
    send_digit(rpd_pkg::OP_MUL, 4'd9, 4'd9, 1'b0);
    send_digit(rpd_pkg::OP_MUL, 4'd9, 4'd9, 1'b1);
    send_digit(rpd_pkg::OP_MUL, 4'd7, 4'd0, 1'b1);
    send_digit(rpd_pkg::OP_DIV, 4'd9, 4'd4, 1'b0);
    send_digit(rpd_pkg::OP_DIV, 4'd7, 4'd4, 1'b1);
    send_digit(rpd_pkg::OP_DIV, 4'd5, 4'd0, 1'b0);      // zero divisor, mid and last
    send_digit(rpd_pkg::OP_DIV, 4'd5, 4'd0, 1'b1);
    send_digit(rpd_pkg::OP_ADD, 4'd15, 4'd0, 1'b0);     // digits outside the radix
    send_digit(rpd_pkg::OP_ADD, 4'd0, 4'd10, 1'b1);
    send_digit(rpd_pkg::OP_ADD, 4'd9, 4'd9, 1'b0);      // carry dropped by a bad last digit
    send_digit(rpd_pkg::OP_SUB, 4'd12, 4'd1, 1'b1);
    send_digit(rpd_pkg::OP_ADD, 4'd9, 4'd9, 1'b0);      // op switched mid-number
    send_digit(rpd_pkg::OP_SUB, 4'd5, 4'd0, 1'b1);
    send_digit(rpd_pkg::OP_DIV, 4'd9, 4'd1, 1'b0);      // remainder carried into a multiply
    send_digit(rpd_pkg::OP_DIV, 4'd9, 4'd2, 1'b0);
    send_digit(rpd_pkg::OP_MUL, 4'd6, 4'd3, 1'b1);
    drain();

    foreach (base_plan[k]) begin
      write_base(base_plan[k]);
      no_gaps  = (k == 4);
      in_phase = 0;
      while (in_phase < PHASE_ITEMS) begin
        if (k == 2 && !mid_done && in_phase >= 25) begin
          drain();
          mid_done = 1;
        end
        if ($urandom_range(0, 99) < 15) begin
          send_digit(2'($urandom), 4'($urandom), 4'($urandom), 1'($urandom));
          in_phase++;
        end else begin
          op  = 2'($urandom);
          len = $urandom_range(1, 6);
          send_run(op, len, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
          in_phase += len;
        end
      end
      drain();
    end
    no_gaps = 0;

    $display("%0d digits sent across %0d radix settings plus the reset radix", sent,
             $size(base_plan));
    $display("%0d result beats checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("radix_p_digit_serial_arithmetic_tb passed");
    end else begin
      $display("radix_p_digit_serial_arithmetic_tb failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/rpd_pkg.sv
design/rpd_if.sv
design/rpd_div.sv
design/radix_p_digit_serial_arithmetic.sv
sim/rpd_digit_monitor.sv
sim/radix_p_digit_serial_arithmetic_tb.sv
